// File: rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants and types for the scan code set 1 key decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned KEYMAP_DEPTH = 512;
  localparam int unsigned KEYMAP_AW    = 9;
  localparam int unsigned CHAR_W       = 8;

  // item kinds on the input channel
  localparam logic MODE_SCAN    = 1'b0;
  localparam logic MODE_MAP_WR  = 1'b1;

  localparam logic [7:0] CODE_EXT_PREFIX = 8'hE0;

  // key codes with bit 7 dropped
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_NUM    = 7'h45;

  // modifier word bit positions
  localparam int unsigned MOD_LSHIFT = 0;
  localparam int unsigned MOD_RSHIFT = 1;
  localparam int unsigned MOD_LALT   = 2;
  localparam int unsigned MOD_RALT   = 3;
  localparam int unsigned MOD_CAPS   = 4;
  localparam int unsigned MOD_NUM    = 5;
  localparam int unsigned MOD_LCTRL  = 6;
  localparam int unsigned MOD_RCTRL  = 7;

  typedef struct packed {
    logic       emit;
    logic [7:0] key_code;
    logic       released;
    logic [7:0] modifiers;
    logic       char_only;
  } evt_t;

endpackage

// File: rtl/scd_ram.sv
// ----------------------------------------------------------------------------
// scd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/scd_decode.sv
// ----------------------------------------------------------------------------
// scd_decode
// Scan byte decode: extended prefix flag, modifier word and keymap address.
// ----------------------------------------------------------------------------
module scd_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_en,
  input  logic                            mode,
  input  logic [7:0]                      scan_byte,
  input  logic                            raw_mode,
  output scd_pkg::evt_t                   evt,
  output logic [scd_pkg::KEYMAP_AW-1:0]   lookup_addr
);

  logic       ext_r, ext_nxt;
  logic [7:0] mods_r, mods_nxt;
  logic [6:0] low;
  logic       rel;
  logic [7:0] code;
  logic       shift_held;
  logic       ralt_held;

  assign low        = scan_byte[6:0];
  assign rel        = scan_byte[7];
  assign shift_held = mods_r[scd_pkg::MOD_LSHIFT] | mods_r[scd_pkg::MOD_RSHIFT];
  assign ralt_held  = mods_r[scd_pkg::MOD_RALT];
  assign code       = {ext_r, low};

  // layer select: +0x80 for shift, +0x100 for right alt, wraps at 9 bits
  assign lookup_addr = {1'b0, code} + {1'b0, shift_held, 7'b0} + {ralt_held, 8'b0};

  always_comb begin
    ext_nxt       = ext_r;
    mods_nxt      = mods_r;
    evt.emit      = 1'b0;
    evt.key_code  = code;
    evt.released  = rel;
    evt.modifiers = mods_r;
    evt.char_only = 1'b0;
    if (item_en && mode == scd_pkg::MODE_SCAN) begin
      if (ext_r) begin
        ext_nxt = 1'b0;
        if (low == scd_pkg::KEY_CTRL) begin
          mods_nxt[scd_pkg::MOD_RCTRL] = ~mods_r[scd_pkg::MOD_RCTRL];
        end else if (low == scd_pkg::KEY_ALT) begin
          mods_nxt[scd_pkg::MOD_RALT] = ~mods_r[scd_pkg::MOD_RALT];
        end else begin
          evt.emit = raw_mode;
        end
      end else if (scan_byte == scd_pkg::CODE_EXT_PREFIX) begin
        ext_nxt = 1'b1;
      end else begin
        case (low)
          scd_pkg::KEY_CTRL:   mods_nxt[scd_pkg::MOD_LCTRL]  = ~mods_r[scd_pkg::MOD_LCTRL];
          scd_pkg::KEY_LSHIFT: mods_nxt[scd_pkg::MOD_LSHIFT] = ~mods_r[scd_pkg::MOD_LSHIFT];
          scd_pkg::KEY_RSHIFT: mods_nxt[scd_pkg::MOD_RSHIFT] = ~mods_r[scd_pkg::MOD_RSHIFT];
          scd_pkg::KEY_ALT:    mods_nxt[scd_pkg::MOD_LALT]   = ~mods_r[scd_pkg::MOD_LALT];
          scd_pkg::KEY_CAPS:   mods_nxt[scd_pkg::MOD_CAPS]   = ~mods_r[scd_pkg::MOD_CAPS];
          scd_pkg::KEY_NUM:    mods_nxt[scd_pkg::MOD_NUM]    = ~mods_r[scd_pkg::MOD_NUM];
          default: begin
            evt.emit = raw_mode | rel;
            if (!raw_mode) begin
              // cooked: character alone
              evt.key_code  = 8'h00;
              evt.released  = 1'b0;
              evt.modifiers = 8'h00;
              evt.char_only = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r  <= 1'b0;
      mods_r <= 8'h00;
    end else begin
      ext_r  <= ext_nxt;
      mods_r <= mods_nxt;
    end
  end

endmodule

// File: rtl/scancode_set1_key_decoder.sv
// ----------------------------------------------------------------------------
// scancode_set1_key_decoder
// PS/2 scan code set 1 decoder with a four-layer 512-entry keymap.
// ----------------------------------------------------------------------------
// Takes one request per clock: a scan code byte or a keymap entry write. A key
// request that yields an event passes the lookup stage, where the keymap RAM
// read is registered, and then the output register before it appears on the
// out channel. A lookup stage and an output register sit in line, so a new
// request is taken while a finished event waits; the input stalls only when
// both are full. The keymap holds no reset value: every entry must be written
// before a key that selects it is decoded. cfg_wr_data sets raw mode (reset 1).
module scancode_set1_key_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_scan_byte,
  input  logic [8:0] in_map_index,
  input  logic [7:0] in_map_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_key_code,
  output logic       out_released,
  output logic [7:0] out_character,
  output logic [7:0] out_modifiers,
  output logic       out_char_only
);

  logic                          raw_mode_r;
  logic                          accept;
  logic                          out_load;
  scd_pkg::evt_t                 evt;
  logic [scd_pkg::KEYMAP_AW-1:0] lookup_addr;
  logic [scd_pkg::CHAR_W-1:0]    ram_rd_data;
  logic                          map_wr;

  logic                          s1_valid_r, s1_valid_nxt;
  scd_pkg::evt_t                 s1_evt_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_key_code_r;
  logic                          out_released_r;
  logic [7:0]                    out_character_r;
  logic [7:0]                    out_modifiers_r;
  logic                          out_char_only_r;

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign accept   = in_valid && !in_stall;
  assign map_wr   = accept && (in_mode == scd_pkg::MODE_MAP_WR);

  scd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (accept),
    .mode        (in_mode),
    .scan_byte   (in_scan_byte),
    .raw_mode    (raw_mode_r),
    .evt         (evt),
    .lookup_addr (lookup_addr)
  );

  scd_ram #(
    .WIDTH (scd_pkg::CHAR_W),
    .DEPTH (scd_pkg::KEYMAP_DEPTH)
  ) u_keymap (
    .clk     (clk),
    .wr_en   (map_wr),
    .wr_addr (in_map_index),
    .wr_data (in_map_value),
    .rd_en   (evt.emit),
    .rd_addr (lookup_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    s1_valid_nxt  = (s1_valid_r && !out_load) || evt.emit;
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r  <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        raw_mode_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.emit) begin
      s1_evt_r <= evt;
    end
    if (out_load && s1_valid_r) begin
      out_key_code_r  <= s1_evt_r.key_code;
      out_released_r  <= s1_evt_r.released;
      out_character_r <= ram_rd_data;
      out_modifiers_r <= s1_evt_r.modifiers;
      out_char_only_r <= s1_evt_r.char_only;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_key_code_r;
  assign out_released  = out_released_r;
  assign out_character = out_character_r;
  assign out_modifiers = out_modifiers_r;
  assign out_char_only = out_char_only_r;

  // lookup stage drains into the output register unless that is blocked
  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_load) |=> out_valid_r)
    else $error("lookup stage lost a request");

  // a blocked lookup stage must hold off new requests
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while pipeline full");

  // cooked events carry only the character
  a_cooked_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_only_r) |->
      (out_key_code_r == 8'h00 && !out_released_r && out_modifiers_r == 8'h00))
    else $error("cooked event has nonzero side fields");

  // a stalled event stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_character_r)))
    else $error("stalled event changed");

endmodule

// File: verif/tb_scancode_set1_key_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_set1_key_decoder
// Drives scan code bytes and keymap writes into the decoder, tracks the
// extended prefix, modifier word and keymap alongside it, and checks every
// key event in order, in raw and cooked mode, under random and long stalls.
// ----------------------------------------------------------------------------
module tb_scancode_set1_key_decoder;

  localparam logic [7:0] BREAK_BIT   = 8'h80;
  localparam int         HOLD_CYCLES = 60;

  typedef struct packed {
    logic [7:0] key_code;
    logic       released;
    logic [7:0] character;
    logic [7:0] modifiers;
    logic       char_only;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = scd_pkg::MODE_SCAN;
  logic [7:0] in_scan_byte = 8'h00;
  logic [8:0] in_map_index = 9'h000;
  logic [7:0] in_map_value = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_key_code;
  logic       out_released;
  logic [7:0] out_character;
  logic [7:0] out_modifiers;
  logic       out_char_only;

  // decoder state as seen from outside
  logic       raw_mode_q = 1'b1;
  logic       ext_pending_q = 1'b0;
  logic [7:0] mod_word = 8'h00;
  logic [7:0] keymap_mirror [scd_pkg::KEYMAP_DEPTH];
  bit         keymap_written [scd_pkg::KEYMAP_DEPTH];

  key_event_t key_events_due [$];
  int         mismatch_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       hold_trig = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;

  scancode_set1_key_decoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_scan_byte (in_scan_byte),
    .in_map_index (in_map_index),
    .in_map_value (in_map_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code),
    .out_released (out_released),
    .out_character(out_character),
    .out_modifiers(out_modifiers),
    .out_char_only(out_char_only)
  );

  always #10 clk = ~clk;

  function automatic logic [8:0] layer_index(input logic [7:0] code);
    logic [8:0] idx;
    idx = {1'b0, code};
    if (mod_word[scd_pkg::MOD_LSHIFT] || mod_word[scd_pkg::MOD_RSHIFT]) idx = idx + 9'h080;
    if (mod_word[scd_pkg::MOD_RALT]) idx = idx + 9'h100;
    return idx;
  endfunction

  function automatic bit is_plain_modifier(input logic [6:0] low);
    return low == scd_pkg::KEY_CTRL || low == scd_pkg::KEY_LSHIFT ||
           low == scd_pkg::KEY_RSHIFT || low == scd_pkg::KEY_ALT ||
           low == scd_pkg::KEY_CAPS || low == scd_pkg::KEY_NUM;
  endfunction

  // keymap entry that a scan byte would read in the current state, if any
  function automatic bit scan_reads_keymap(input logic [7:0] sb, output logic [8:0] idx);
    idx = '0;
    if (ext_pending_q) begin
      if (sb[6:0] == scd_pkg::KEY_CTRL || sb[6:0] == scd_pkg::KEY_ALT) return 1'b0;
      idx = layer_index(sb | BREAK_BIT);
      return 1'b1;
    end
    if (sb == scd_pkg::CODE_EXT_PREFIX || is_plain_modifier(sb[6:0])) return 1'b0;
    idx = layer_index({1'b0, sb[6:0]});
    return 1'b1;
  endfunction

  function automatic void decode_scan_request(input logic m, input logic [7:0] sb,
                                              input logic [8:0] mi, input logic [7:0] mv);
    logic [6:0] low;
    logic [7:0] code;
    key_event_t ev;
    if (m == scd_pkg::MODE_MAP_WR) begin
      keymap_mirror[mi] = mv;
      keymap_written[mi] = 1'b1;
      return;
    end
    low = sb[6:0];
    if (ext_pending_q) begin
      ext_pending_q = 1'b0;
      if (low == scd_pkg::KEY_CTRL)
        mod_word[scd_pkg::MOD_RCTRL] = ~mod_word[scd_pkg::MOD_RCTRL];
      else if (low == scd_pkg::KEY_ALT)
        mod_word[scd_pkg::MOD_RALT] = ~mod_word[scd_pkg::MOD_RALT];
      else if (raw_mode_q) begin
        code = sb | BREAK_BIT;
        ev = '{code, sb[7], keymap_mirror[layer_index(code)], mod_word, 1'b0};
        key_events_due.push_back(ev);
      end
      return;
    end
    if (sb == scd_pkg::CODE_EXT_PREFIX) begin
      ext_pending_q = 1'b1;
      return;
    end
    case (low)
      scd_pkg::KEY_CTRL:   mod_word[scd_pkg::MOD_LCTRL]  = ~mod_word[scd_pkg::MOD_LCTRL];
      scd_pkg::KEY_LSHIFT: mod_word[scd_pkg::MOD_LSHIFT] = ~mod_word[scd_pkg::MOD_LSHIFT];
      scd_pkg::KEY_RSHIFT: mod_word[scd_pkg::MOD_RSHIFT] = ~mod_word[scd_pkg::MOD_RSHIFT];
      scd_pkg::KEY_ALT:    mod_word[scd_pkg::MOD_LALT]   = ~mod_word[scd_pkg::MOD_LALT];
      scd_pkg::KEY_CAPS:   mod_word[scd_pkg::MOD_CAPS]   = ~mod_word[scd_pkg::MOD_CAPS];
      scd_pkg::KEY_NUM:    mod_word[scd_pkg::MOD_NUM]    = ~mod_word[scd_pkg::MOD_NUM];
      default: begin
        code = {1'b0, low};
        if (raw_mode_q) begin
          ev = '{code, sb[7], keymap_mirror[layer_index(code)], mod_word, 1'b0};
          key_events_due.push_back(ev);
        end else if (sb[7]) begin
          ev = '{8'h00, 1'b0, keymap_mirror[layer_index(code)], 8'h00, 1'b1};
          key_events_due.push_back(ev);
        end
      end
    endcase
  endfunction

  function automatic void check_key_event();
    key_event_t got, want;
    got = '{out_key_code, out_released, out_character, out_modifiers, out_char_only};
    if (key_events_due.size() == 0) begin
      if (mismatch_count < 10)
        $display("unexpected event: code %h rel %b char %h mods %h char_only %b",
                 got.key_code, got.released, got.character, got.modifiers, got.char_only);
      mismatch_count++;
      return;
    end
    want = key_events_due.pop_front();
    if (got.key_code !== want.key_code || got.released !== want.released ||
        got.character !== want.character || got.modifiers !== want.modifiers ||
        got.char_only !== want.char_only) begin
      if (mismatch_count < 10) begin
        $display("event mismatch: expected code %h rel %b char %h mods %h char_only %b",
                 want.key_code, want.released, want.character, want.modifiers,
                 want.char_only);
        $display("                got      code %h rel %b char %h mods %h char_only %b",
                 got.key_code, got.released, got.character, got.modifiers, got.char_only);
      end
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) check_key_event();
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_req(input logic m, input logic [7:0] sb,
                          input logic [8:0] mi, input logic [7:0] mv);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_scan_byte <= sb;
    in_map_index <= mi;
    in_map_value <= mv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    decode_scan_request(m, sb, mi, mv);
  endtask

  task automatic send_map(input logic [8:0] idx, input logic [7:0] val);
    send_req(scd_pkg::MODE_MAP_WR, 8'($urandom_range(255)), idx, val);
  endtask

  // fills the keymap entry the byte will read first, if still unwritten
  task automatic send_scan(input logic [7:0] sb);
    logic [8:0] idx;
    if (scan_reads_keymap(sb, idx) && !keymap_written[idx])
      send_map(idx, 8'($urandom_range(255)));
    send_req(scd_pkg::MODE_SCAN, sb, 9'($urandom_range(511)), 8'($urandom_range(255)));
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (key_events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_raw_mode(input logic raw);
    drain_events();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= raw;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    raw_mode_q = raw;
  endtask

  task automatic run_random_traffic(input int n_req);
    int kind;
    logic [7:0] b;
    logic [6:0] mod_keys [6];
    mod_keys = '{scd_pkg::KEY_LSHIFT, scd_pkg::KEY_RSHIFT, scd_pkg::KEY_ALT,
                 scd_pkg::KEY_CAPS, scd_pkg::KEY_NUM, scd_pkg::KEY_CTRL};
    for (int k = 0; k < n_req; k++) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        send_map(9'($urandom_range(511)), 8'($urandom_range(255)));
      end else if (kind < 65) begin
        // ordinary key, sometimes extended
        if ($urandom_range(3) == 0) send_scan(scd_pkg::CODE_EXT_PREFIX);
        send_scan(8'($urandom_range(255)));
      end else if (kind < 85) begin
        b = {1'b0, mod_keys[$urandom_range(5)]};
        b[7] = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) send_scan(scd_pkg::CODE_EXT_PREFIX);
        send_scan(b);
      end else begin
        send_scan(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_keymap_extremes();
    send_map(9'h000, 8'h00);
    send_map(9'h1FF, 8'hFF);
  endtask

  task automatic test_raw_keys();
    send_scan(8'h00);
    send_scan(8'hFF);
    send_scan({1'b0, scd_pkg::KEY_LSHIFT});
    send_scan({1'b0, scd_pkg::KEY_RSHIFT});
    send_scan(8'h7F);
    send_scan(BREAK_BIT | scd_pkg::KEY_RSHIFT);
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan({1'b0, scd_pkg::KEY_ALT});
    // shift plus right alt on an extended code wraps past the top entry
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_map(9'h0AB, 8'h5A);
    send_scan(8'hFF);
    send_scan(BREAK_BIT | scd_pkg::KEY_LSHIFT);
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan(BREAK_BIT | scd_pkg::KEY_ALT);
    // a second prefix byte is taken as the extended key
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan({1'b0, scd_pkg::KEY_CTRL});
    send_scan({1'b0, scd_pkg::KEY_CTRL});
    send_scan(BREAK_BIT | scd_pkg::KEY_CAPS);
    send_scan({1'b0, scd_pkg::KEY_NUM});
    send_scan(BREAK_BIT | scd_pkg::KEY_ALT);
    send_scan(8'h1C);
  endtask

  task automatic test_cooked_keys();
    set_raw_mode(1'b0);
    send_scan(scd_pkg::CODE_EXT_PREFIX);
    send_scan(8'h9C);
    send_scan(8'h1C);
    send_scan(8'h9C);
    send_scan({1'b0, scd_pkg::KEY_LSHIFT});
    send_scan(8'h9C);
    send_scan(BREAK_BIT | scd_pkg::KEY_LSHIFT);
  endtask

  task automatic test_random_cooked();
    tx_idle_pct = 19;
    rx_idle_pct <= 45;
    run_random_traffic(170);
  endtask

  task automatic test_receiver_hold();
    set_raw_mode(1'b1);
    tx_idle_pct = 45;
    rx_idle_pct <= 19;
    hold_trig <= ~hold_trig;
    run_random_traffic(200);
  endtask

  task automatic test_no_idle();
    set_raw_mode(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_random_traffic(90);
    set_raw_mode(1'b1);
    hold_trig <= ~hold_trig;
    run_random_traffic(90);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 19;
    rx_idle_pct <= 45;
    test_keymap_extremes();
    test_raw_keys();
    test_cooked_keys();
    test_random_cooked();
    test_receiver_hold();
    test_no_idle();
    drain_events();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
